// ===== rtl/core/crti_pkg.sv =====
// Shared types and constants for the Catmull-Rom table interpolator.
// Depends on nothing; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package crti_pkg;

  // Table geometry.
  localparam int TABLE_SIZE = 8;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  // Scaled position p = pos * (TABLE_SIZE - 1) stays below 2^16 * TABLE_SIZE.
  localparam int P_W        = 16 + IDX_W;

  // Fixed-point constants.
  localparam int ONE_Q14    = 16384;
  localparam int POS_END    = 65536;
  localparam int MIN_SCALE  = 4;

  // Datapath widths.
  localparam int C_W        = 20;   // cubic coefficients, signed
  localparam int PROD_W     = 37;   // C_W x 17 signed product
  localparam int ACC_W      = 40;   // weighted sum, signed
  localparam int FRAC_SHIFT = 17;   // sum is divided by 2^17

  // Sample normalization divider: 30 quotient bits, one per cycle.
  localparam int DIV_STEPS  = 30;
  localparam int DIV_CNT_W  = 5;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register map (word index taken from paddr[2]).
  localparam logic REG_MAX_ABS = 1'b0;
  localparam logic [14:0] MAX_ABS_RESET = 15'd4096;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_WR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_MAC1,
    ST_MAC2,
    ST_MAC3,
    ST_MAC4,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/catmull_rom_table_interpolator_top.sv =====
// Top level of the Catmull-Rom table interpolator: sample table memory,
// bit-serial normalization divider and a shared-multiplier cubic sequencer.
// Depends on crti_pkg.
//
//   channel   direction  handshake                      payload
//   request   in         start & !busy                  req_type, table_index,
//                                                       sample_value, position
//   result    out        result_valid_o (one cycle)     interp_value_o
//   config    in         psel & penable & pwrite        pwdata (max_abs at 0x0)
//
// A query keeps busy high while it makes the four neighbour reads through the
// single synchronous read port, runs the multiply-accumulate steps on one shared
// multiplier and applies the final scale and clamp.
// The result strobe appears in the first cycle with busy low again.
// A write keeps busy high while the divider yields one quotient bit per cycle
// (30 bits) and then the table is written.
// Reset sets max_abs to 4096; table entries are undefined until written.
// The result port has no back-pressure; start is ignored while busy is high.
`timescale 1ns / 1ps

module catmull_rom_table_interpolator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request word
  input  logic                start,
  output logic                busy,
  input  logic                req_type_i,
  input  logic [7:0]          table_index_i,
  input  logic signed [15:0]  sample_value_i,
  input  logic [16:0]         position_i,
  // result word
  output logic                result_valid_o,
  output logic signed [15:0]  interp_value_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W = crti_pkg::IDX_W;
  localparam int P_W   = crti_pkg::P_W;
  localparam int C_W   = crti_pkg::C_W;
  localparam int ACC_W = crti_pkg::ACC_W;

  crti_pkg::state_e state_q, state_d;

  // Configuration.
  logic [14:0] max_abs_q;
  logic        cfg_we;

  // Table memory.
  logic signed [15:0] mem [crti_pkg::TABLE_SIZE];
  logic signed [15:0] rdata_q;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_we;
  logic signed [15:0] mem_wdata;

  // Write path.
  logic [7:0]                     widx_q;
  logic                           neg_q;
  logic [15:0]                    rem_q;
  logic [crti_pkg::DIV_STEPS-1:0] dvd_q;
  logic [crti_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [14:0]                    scale;
  logic [15:0]                    trial;
  logic                           trial_ge;
  logic [15:0]                    raw_mag;
  logic [14:0]                    q_mag;

  // Query path.
  logic [P_W-1:0]     p_q;
  logic [P_W-1:0]     p_d;
  logic [16:0]        pos_c;
  logic [15:0]        frac;
  logic [IDX_W-1:0]   base_idx;
  logic [1:0]         rd_off;
  logic [15:0]        a2_q, a3_q;
  logic signed [15:0] p0_q, p1_q, p2_q;
  logic signed [16:0] c1_q;
  logic signed [C_W-1:0] c2_q, c3_q;
  logic signed [C_W-1:0] mul_a;
  logic signed [16:0]    mul_b;
  logic signed [crti_pkg::PROD_W-1:0] prod, prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] acc_div;
  logic signed [15:0]      result_q;
  logic                    result_valid_q;

  logic accept;

  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == crti_pkg::REG_MAX_ABS);
  assign prdata = (paddr[2] == crti_pkg::REG_MAX_ABS) ? {17'd0, max_abs_q} : 32'd0;

  // Neighbour index for offset 0..3 meaning idx-1 .. idx+2, clamped to the table.
  function automatic logic [IDX_W-1:0] nbr_index(input logic [IDX_W-1:0] idx,
                                                 input logic [1:0] off);
    logic [IDX_W+1:0] sum;
    sum = (IDX_W+2)'(idx) + (IDX_W+2)'(off);
    if (sum == '0) begin
      return '0;
    end
    sum = sum - (IDX_W+2)'(1);
    if (sum > (IDX_W+2)'(crti_pkg::TABLE_SIZE - 1)) begin
      return IDX_W'(crti_pkg::TABLE_SIZE - 1);
    end
    return sum[IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crti_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (req_type_i == crti_pkg::REQ_WRITE) ? crti_pkg::ST_DIV
                                                        : crti_pkg::ST_RD0;
        end
      end
      crti_pkg::ST_DIV: begin
        if (div_cnt_q == crti_pkg::DIV_CNT_W'(crti_pkg::DIV_STEPS - 1)) begin
          state_d = crti_pkg::ST_WR;
        end
      end
      crti_pkg::ST_WR:   state_d = crti_pkg::ST_IDLE;
      crti_pkg::ST_RD0:  state_d = crti_pkg::ST_RD1;
      crti_pkg::ST_RD1:  state_d = crti_pkg::ST_RD2;
      crti_pkg::ST_RD2:  state_d = crti_pkg::ST_RD3;
      crti_pkg::ST_RD3:  state_d = crti_pkg::ST_RD4;
      crti_pkg::ST_RD4:  state_d = crti_pkg::ST_MAC1;
      crti_pkg::ST_MAC1: state_d = crti_pkg::ST_MAC2;
      crti_pkg::ST_MAC2: state_d = crti_pkg::ST_MAC3;
      crti_pkg::ST_MAC3: state_d = crti_pkg::ST_MAC4;
      crti_pkg::ST_MAC4: state_d = crti_pkg::ST_DONE;
      crti_pkg::ST_DONE: state_d = crti_pkg::ST_IDLE;
      default:           state_d = crti_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // State outputs: handshake, memory port and multiplier operand selection
  // ---------------------------------------------------------------------
  always_comb begin
    busy   = 1'b1;
    mem_we = 1'b0;
    rd_off = 2'd0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      crti_pkg::ST_IDLE: busy = 1'b0;
      crti_pkg::ST_WR: begin
        mem_we = ({1'b0, widx_q} < 9'(crti_pkg::TABLE_SIZE));
      end
      crti_pkg::ST_RD0: begin
        rd_off = 2'd0;
        mul_a  = C_W'({1'b0, frac});
        mul_b  = {1'b0, frac};
      end
      crti_pkg::ST_RD1: begin
        rd_off = 2'd1;
        // prod_q holds a*a here; its upper half is a2.
        mul_a  = C_W'({1'b0, prod_q[31:16]});
        mul_b  = {1'b0, frac};
      end
      crti_pkg::ST_RD2: rd_off = 2'd2;
      crti_pkg::ST_RD3: rd_off = 2'd3;
      crti_pkg::ST_MAC1: begin
        mul_a = C_W'(c1_q);
        mul_b = {1'b0, frac};
      end
      crti_pkg::ST_MAC2: begin
        mul_a = c2_q;
        mul_b = {1'b0, a2_q};
      end
      crti_pkg::ST_MAC3: begin
        mul_a = c3_q;
        mul_b = {1'b0, a3_q};
      end
      default: ;
    endcase
  end

  assign frac      = p_q[15:0];
  assign base_idx  = p_q[16 +: IDX_W];
  assign mem_raddr = nbr_index(base_idx, rd_off);
  assign prod      = mul_a * mul_b;

  // Query position scaled onto the table span.
  assign pos_c = (position_i > 17'(crti_pkg::POS_END)) ? 17'(crti_pkg::POS_END) : position_i;
  assign p_d   = P_W'(P_W'(pos_c) * P_W'(crti_pkg::TABLE_SIZE - 1));

  // Restoring divider step on |sample| * 2^14 by max(max_abs, 4).
  assign scale    = (max_abs_q < 15'(crti_pkg::MIN_SCALE)) ? 15'(crti_pkg::MIN_SCALE)
                                                            : max_abs_q;
  assign trial    = {rem_q[14:0], dvd_q[crti_pkg::DIV_STEPS-1]};
  assign trial_ge = (trial >= {1'b0, scale});
  assign raw_mag  = sample_value_i[15] ? 16'(-sample_value_i) : 16'(sample_value_i);

  assign q_mag     = (dvd_q > crti_pkg::DIV_STEPS'(crti_pkg::ONE_Q14)) ? 15'(crti_pkg::ONE_Q14)
                                                                      : dvd_q[14:0];
  assign mem_wdata = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  // Division by 2^17 rounding toward zero.
  assign acc_adj = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << crti_pkg::FRAC_SHIFT) - 1)
                                           : ACC_W'(0));
  assign acc_div = acc_adj >>> crti_pkg::FRAC_SHIFT;

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= crti_pkg::ST_IDLE;
      div_cnt_q      <= '0;
      result_valid_q <= 1'b0;
      max_abs_q      <= crti_pkg::MAX_ABS_RESET;
    end else begin
      state_q        <= state_d;
      result_valid_q <= (state_q == crti_pkg::ST_DONE);
      if (state_q == crti_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + crti_pkg::DIV_CNT_W'(1);
      end else begin
        div_cnt_q <= '0;
      end
      if (cfg_we) begin
        max_abs_q <= pwdata[14:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    if (accept) begin
      widx_q <= table_index_i;
      neg_q  <= sample_value_i[15];
      rem_q  <= '0;
      dvd_q  <= {raw_mag, 14'd0};
      p_q    <= p_d;
    end
    unique case (state_q)
      crti_pkg::ST_DIV: begin
        rem_q <= trial_ge ? (trial - {1'b0, scale}) : trial;
        dvd_q <= {dvd_q[crti_pkg::DIV_STEPS-2:0], trial_ge};
      end
      crti_pkg::ST_RD1: begin
        a2_q <= prod_q[31:16];
        p0_q <= rdata_q;
      end
      crti_pkg::ST_RD2: begin
        a3_q <= prod_q[31:16];
        p1_q <= rdata_q;
      end
      crti_pkg::ST_RD3: p2_q <= rdata_q;
      crti_pkg::ST_RD4: begin
        // rdata_q carries p3 in this cycle.
        c1_q <= 17'(p2_q) - 17'(p0_q);
        c2_q <= (C_W'(p0_q) <<< 1) - ((C_W'(p1_q) <<< 2) + C_W'(p1_q))
                + (C_W'(p2_q) <<< 2) - C_W'(rdata_q);
        c3_q <= ((C_W'(p1_q) <<< 1) + C_W'(p1_q)) - C_W'(p0_q)
                - ((C_W'(p2_q) <<< 1) + C_W'(p2_q)) + C_W'(rdata_q);
      end
      crti_pkg::ST_MAC1: acc_q <= ACC_W'(p1_q) <<< crti_pkg::FRAC_SHIFT;
      crti_pkg::ST_MAC2,
      crti_pkg::ST_MAC3,
      crti_pkg::ST_MAC4: acc_q <= acc_q + ACC_W'(prod_q);
      crti_pkg::ST_DONE: begin
        if (acc_div > ACC_W'(crti_pkg::ONE_Q14)) begin
          result_q <= 16'(crti_pkg::ONE_Q14);
        end else if (acc_div < -ACC_W'(crti_pkg::ONE_Q14)) begin
          result_q <= -16'(crti_pkg::ONE_Q14);
        end else begin
          result_q <= acc_div[15:0];
        end
      end
      default: ;
    endcase
  end

  // Sample table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[widx_q[IDX_W-1:0]] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign result_valid_o = result_valid_q;
  assign interp_value_o = result_q;

`ifndef SYNTHESIS
  // A query produces exactly one single-cycle strobe.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // Results stay within plus or minus one in Q1.14.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (interp_value_o <= 16'sd16384 && interp_value_o >= -16'sd16384))
    else $error("interpolated value outside plus or minus one");

  // A strobe only follows the final scaling cycle.
  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == crti_pkg::ST_DONE))
    else $error("result strobe without a finished query");

  // An accepted write always starts the normalization divider.
  a_write_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == crti_pkg::REQ_WRITE) |=> (state_q == crti_pkg::ST_DIV))
    else $error("accepted write did not enter the divider");
`endif

endmodule
